FILE: rtl/mcfq_pkg.sv
// Shared types, constants and the CRC-16 byte step for the Modbus command frame queue.
package mcfq_pkg;

   // Frame ring
   localparam int QUEUE_DEPTH = 5;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // Byte counter covers the eight bytes of a frame
   localparam int FRAME_BYTES = 8;
   localparam int CNT_W       = $clog2(FRAME_BYTES);
   localparam int CRC_BYTES   = 6;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLAVE_ADDR  = 3'd0,
      CSR_READ_FUNC   = 3'd1,
      CSR_READ_COUNT  = 3'd2,
      CSR_ANGLE_LIMIT = 3'd3,
      CSR_SPEED_LIMIT = 3'd4
   } csr_index_type;

   // Reset values of the configuration registers
   localparam logic [7:0]  RST_SLAVE_ADDR  = 8'd1;
   localparam logic [7:0]  RST_READ_FUNC   = 8'd3;
   localparam logic [15:0] RST_READ_COUNT  = 16'd10;
   localparam logic [14:0] RST_ANGLE_LIMIT = 15'd900;
   localparam logic [14:0] RST_SPEED_LIMIT = 15'd50;

   // Actions
   localparam logic ACTION_QUEUE = 1'b0;
   localparam logic ACTION_SEND  = 1'b1;

   // Command types
   localparam logic [7:0] CTRL_ANGLE = 8'd1;
   localparam logic [7:0] CTRL_START = 8'd2;
   localparam logic [7:0] CTRL_HOME  = 8'd3;
   localparam logic [7:0] CTRL_STOP  = 8'd4;
   localparam logic [7:0] CTRL_CLEAR = 8'd5;
   localparam logic [7:0] CTRL_SPEED = 8'd6;

   // Modbus registers and values
   localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
   localparam logic [15:0] REG_ANGLE  = 16'h0022;
   localparam logic [15:0] REG_MODE   = 16'h001F;
   localparam logic [15:0] REG_CLEAR  = 16'h0020;
   localparam logic [15:0] REG_SPEED  = 16'h0021;
   localparam logic [15:0] VAL_START  = 16'h0002;
   localparam logic [15:0] VAL_HOME   = 16'h0003;
   localparam logic [15:0] VAL_STOP   = 16'h0001;
   localparam logic [15:0] VAL_CLEAR  = 16'hFFFF;
   localparam logic [15:0] READ_START = 16'h0000;

   // CRC-16/MODBUS
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic FRAME_CTRL = 1'b0;
   localparam logic FRAME_READ = 1'b1;

   typedef struct packed {
      logic        action;
      logic [7:0]  ctrl_type;
      logic signed [15:0] param;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        last_byte;
      logic        frame_kind;
      logic signed [15:0] reported_angle;
   } rsp_payload_type;

   typedef struct packed {
      logic init;
      logic step;
   } crc_ctl_type;

   // One byte through the reflected CRC-16, eight bit steps
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: rtl/mcfq_crc.sv
// Shared CRC-16/MODBUS unit: folds in one frame byte per step.
module mcfq_crc (
   input  logic                clock,
   input  mcfq_pkg::crc_ctl_type ctl,
   input  logic [7:0]          data,
   output logic [15:0]         crc
);
   import mcfq_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (ctl.init) begin
         crc_in = CRC_INIT;
      end else if (ctl.step) begin
         crc_in = crc16_byte(crc_ff, data);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

FILE: rtl/modbus_command_frame_queue_core.sv
// Modbus RTU command frame queue: builds write frames into a ring, sends them on tick.
// Queue command: busy through accept, CRC of six bytes on the shared CRC unit, ring write.
// Send tick, ring holds a frame: registered ring read, then 8 words, one per unstalled cycle.
// Send tick, ring empty: build the read request and its CRC, then 8 words.
// One item in flight; req_stall is high until the last word of a tick has been taken.
// Sync reset clears pointers and command history, presets config; ring contents undefined.
module modbus_command_frame_queue_core (
   input  logic                      clock,
   input  logic                      reset,
   // command input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mcfq_pkg::req_payload_type req_payload,
   // frame byte output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mcfq_pkg::rsp_payload_type rsp_payload,
   // configuration
   input  logic                      csr_we,
   input  logic [mcfq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcfq_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mcfq_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CRC    = 5'b00010,
      ST_FINISH = 5'b00100,
      ST_FETCH  = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;          // CRC byte index, then output byte index
   logic [63:0]       frame_ff, frame_in;      // byte 0 in the low bits
   logic              kind_ff, kind_in;
   logic              store_ff, store_in;      // frame goes to the ring, not the wire
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [15:0]       prev_addr_ff, prev_addr_in;
   logic [15:0]       prev_val_ff, prev_val_in;
   logic signed [15:0] last_angle_ff, last_angle_in;

   logic [7:0]        slave_addr_ff;
   logic [7:0]        read_func_ff;
   logic [15:0]       read_count_ff;
   logic [14:0]       angle_limit_ff;
   logic [14:0]       speed_limit_ff;

   // Frame ring
   logic [63:0]       queue_mem [QUEUE_DEPTH];
   logic [63:0]       rd_data_ff;
   logic              mem_we;

   // Shared CRC unit
   crc_ctl_type       crc_ctl;
   logic [7:0]        crc_data;
   logic [15:0]       crc_value;
   logic [63:0]       crc_frame;

   // Command decode
   logic              req_accept;
   logic              rsp_accept;
   logic              ring_empty;
   logic [15:0]       cmd_addr;
   logic [15:0]       cmd_val;
   logic signed [15:0] cmd_angle;
   logic signed [16:0] param_ext;
   logic signed [16:0] lim_pos;
   logic signed [16:0] lim_neg;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign ring_empty = (rd_ptr_ff == wr_ptr_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   assign rsp_payload.tx_byte        = frame_ff[7:0];
   assign rsp_payload.last_byte      = (cnt_ff == CNT_W'(FRAME_BYTES - 1));
   assign rsp_payload.frame_kind     = kind_ff;
   assign rsp_payload.reported_angle = last_angle_ff;

   // Write-single-register payload per command type; unknown types repeat the last one
   always_comb begin
      param_ext = {req_payload.param[15], req_payload.param};
      lim_pos   = $signed({2'b00, angle_limit_ff});
      lim_neg   = -lim_pos;
      cmd_angle = last_angle_ff;
      cmd_addr  = prev_addr_ff;
      cmd_val   = prev_val_ff;

      if (param_ext > lim_pos) begin
         cmd_angle = lim_pos[15:0];
      end else if (param_ext < lim_neg) begin
         cmd_angle = lim_neg[15:0];
      end else begin
         cmd_angle = req_payload.param;
      end

      case (req_payload.ctrl_type)
         CTRL_ANGLE: begin
            cmd_addr = REG_ANGLE;
            cmd_val  = cmd_angle;
         end
         CTRL_START: begin
            cmd_addr = REG_MODE;
            cmd_val  = VAL_START;
         end
         CTRL_HOME: begin
            cmd_addr = REG_MODE;
            cmd_val  = VAL_HOME;
         end
         CTRL_STOP: begin
            cmd_addr = REG_MODE;
            cmd_val  = VAL_STOP;
         end
         CTRL_CLEAR: begin
            cmd_addr = REG_CLEAR;
            cmd_val  = VAL_CLEAR;
         end
         CTRL_SPEED: begin
            cmd_addr = REG_SPEED;
            // negative or over the limit: send the limit
            if (req_payload.param[15] || (req_payload.param > $signed({1'b0, speed_limit_ff}))) begin
               cmd_val = {1'b0, speed_limit_ff};
            end else begin
               cmd_val = req_payload.param;
            end
         end
         default: begin
            cmd_addr = prev_addr_ff;
            cmd_val  = prev_val_ff;
         end
      endcase
   end

   // CRC bytes go in wire order; high byte of each 16-bit field first
   assign crc_data  = frame_ff[8*cnt_ff +: 8];
   assign crc_frame = {crc_value, frame_ff[47:0]};

   mcfq_crc u_crc (
      .clock (clock),
      .ctl   (crc_ctl),
      .data  (crc_data),
      .crc   (crc_value)
   );

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      frame_in      = frame_ff;
      kind_in       = kind_ff;
      store_in      = store_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      prev_addr_in  = prev_addr_ff;
      prev_val_in   = prev_val_ff;
      last_angle_in = last_angle_ff;
      crc_ctl.init  = 1'b0;
      crc_ctl.step  = 1'b0;
      mem_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cnt_in = '0;
               if (req_payload.action == ACTION_QUEUE) begin
                  prev_addr_in = cmd_addr;
                  prev_val_in  = cmd_val;
                  if (req_payload.ctrl_type == CTRL_ANGLE) begin
                     last_angle_in = cmd_angle;
                  end
                  frame_in     = {16'h0000, cmd_val[7:0], cmd_val[15:8],
                                  cmd_addr[7:0], cmd_addr[15:8],
                                  FUNC_WRITE_SINGLE, slave_addr_ff};
                  kind_in      = FRAME_CTRL;
                  store_in     = 1'b1;
                  crc_ctl.init = 1'b1;
                  state_in     = ST_CRC;
               end else if (!ring_empty) begin
                  state_in = ST_FETCH;
               end else begin
                  frame_in     = {16'h0000, read_count_ff[7:0], read_count_ff[15:8],
                                  READ_START[7:0], READ_START[15:8],
                                  read_func_ff, slave_addr_ff};
                  kind_in      = FRAME_READ;
                  store_in     = 1'b0;
                  crc_ctl.init = 1'b1;
                  state_in     = ST_CRC;
               end
            end
         end
         ST_CRC: begin
            crc_ctl.step = 1'b1;
            if (cnt_ff == CNT_W'(CRC_BYTES - 1)) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (store_ff) begin
               mem_we    = 1'b1;
               wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
               state_in  = ST_IDLE;
            end else begin
               frame_in = crc_frame;
               state_in = ST_EMIT;
            end
         end
         ST_FETCH: begin
            // rd_data_ff was read at the tick's accept edge
            frame_in  = rd_data_ff;
            kind_in   = FRAME_CTRL;
            rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_accept) begin
               if (rsp_payload.last_byte) begin
                  state_in = ST_IDLE;
               end else begin
                  frame_in = {8'h00, frame_ff[63:8]};
                  cnt_in   = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         prev_addr_ff  <= '0;
         prev_val_ff   <= '0;
         last_angle_ff <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         prev_addr_ff  <= prev_addr_in;
         prev_val_ff   <= prev_val_in;
         last_angle_ff <= last_angle_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      kind_ff  <= kind_in;
      store_ff <= store_in;
   end

   // Ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[wr_ptr_ff] <= crc_frame;
      end
      rd_data_ff <= queue_mem[rd_ptr_ff];
   end

   // ---------------------------------------------------------------
   // Configuration registers; indexes past the list are ignored
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff  <= RST_SLAVE_ADDR;
         read_func_ff   <= RST_READ_FUNC;
         read_count_ff  <= RST_READ_COUNT;
         angle_limit_ff <= RST_ANGLE_LIMIT;
         speed_limit_ff <= RST_SPEED_LIMIT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SLAVE_ADDR:  slave_addr_ff  <= csr_wdata[7:0];
            CSR_READ_FUNC:   read_func_ff   <= csr_wdata[7:0];
            CSR_READ_COUNT:  read_count_ff  <= csr_wdata;
            CSR_ANGLE_LIMIT: angle_limit_ff <= csr_wdata[14:0];
            CSR_SPEED_LIMIT: speed_limit_ff <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_no_accept_while_emit: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall))
      else $error("input taken while a frame is being sent");

   a_last_word_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_payload.last_byte) |=> (!rsp_valid && !req_stall))
      else $error("frame output did not end after the last word");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff <= PTR_W'(QUEUE_DEPTH - 1)) && (rd_ptr_ff <= PTR_W'(QUEUE_DEPTH - 1)))
      else $error("ring pointer out of range");

   a_write_only_on_queue: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (kind_ff == FRAME_CTRL && $past(state_ff) == ST_CRC))
      else $error("ring written outside a queue command");

endmodule
